FILE: rtl/nicv_leakage_locator_macros.svh
// Assertion macros for the leakage locator RTL.
// Uses the i_clk / i_rst_n names of the including module; no other dependencies.
`ifndef NICV_LEAKAGE_LOCATOR_MACROS_SVH
`define NICV_LEAKAGE_LOCATOR_MACROS_SVH

// expression holds on every clock edge out of reset
`define NICV_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("nicv: invariant violated");

// consequence holds in the same cycle as the trigger
`define NICV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nicv: implication violated");

// consequence holds in the cycle after the trigger
`define NICV_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nicv: next-cycle implication violated");

`endif

FILE: rtl/nicv_pkg.sv
// Shared constants, state encoding and controller/datapath command and status types.
// No dependencies.
package nicv_pkg;

    localparam int POINTS    = 256;
    localparam int CLASSES   = 256;
    localparam int POINT_W   = $clog2(POINTS);
    localparam int CLASS_W   = $clog2(CLASSES);
    localparam int ADDR_W    = CLASS_W + POINT_W;
    localparam int LIMIT_W   = 9;
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 48;
    localparam int CNT_W     = 32;
    localparam int MEAN_W    = 24;
    localparam int DEV_W     = 64;
    localparam int RATIO_W   = 24;
    localparam int K_W       = CLASS_W + 1;
    localparam int S1_W      = 32;
    localparam int S2_W      = 55;
    localparam int STEP_W    = 7;

    localparam logic signed [MEAN_W-1:0] MEAN_MAX  = 24'sh7FFFFF;
    localparam logic signed [MEAN_W-1:0] MEAN_MIN  = 24'sh800000;
    localparam logic [RATIO_W-1:0]       RATIO_MAX = 24'hFFFFFF;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_UPD, ST_MEAN, ST_MEANW, ST_SQ, ST_DEVW,
        ST_WALK, ST_DRAIN, ST_NUM, ST_VGO, ST_VDIV, ST_CHK, ST_QDIV, ST_SQRT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic upd;
        logic mean_go;
        logic mean_cap;
        logic sq;
        logic dev_wr;
        logic walk_rd;
        logic num;
        logic vdiv_go;
        logic var_cap;
        logic chk;
        logic qdiv_go;
        logic sqrt_go;
        logic root_cap;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic walk_last;
        logic pipe_empty;
        logic mean_vld;
        logic sdiv_done;
        logic sqrt_done;
        logic dev_zero;
        logic var_sat;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/nicv_mdiv.sv
// Pipelined signed mean divider: clamp(sum * 256 / count) in Q.8, one request per cycle.
// Depends on nicv_pkg.
module nicv_mdiv (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_vld,
    input  logic signed [nicv_pkg::SUM_W-1:0]      i_sum,
    input  logic        [nicv_pkg::CNT_W-1:0]      i_cnt,
    output logic                                   o_vld,
    output logic signed [nicv_pkg::MEAN_W-1:0]     o_mean,
    output logic                                   o_busy
);
    import nicv_pkg::*;

    localparam int S = MEAN_W;

    logic [S:0]          r_vld;
    logic [CNT_W-1:0]    r_rem  [0:S];
    logic [MEAN_W-1:0]   r_low  [0:S];
    logic [MEAN_W-1:0]   r_quo  [0:S];
    logic [CNT_W-1:0]    r_cnt  [0:S];
    logic [S:0]          r_neg;
    logic [S:0]          r_zero;
    logic [S:0]          r_ovf;

    logic [SUM_W-1:0]    mag;
    logic [MEAN_W-1:0]   q;

    // entry stage: magnitude, top of numerator and range checks
    assign mag = i_sum[SUM_W-1] ? SUM_W'(-i_sum) : i_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= mag[SUM_W-1:16];
        r_low[0]  <= {mag[15:0], 8'h00};
        r_quo[0]  <= '0;
        r_cnt[0]  <= i_cnt;
        r_neg[0]  <= i_sum[SUM_W-1];
        r_zero[0] <= (i_cnt == '0);
        r_ovf[0]  <= (mag[SUM_W-1:16] >= i_cnt);
    end

    // one quotient bit per stage
    for (genvar g = 1; g <= S; g++) begin : g_stage
        logic [CNT_W:0] t;
        logic           ge;
        logic [CNT_W:0] d;

        assign t  = {r_rem[g-1], r_low[g-1][MEAN_W-1]};
        assign ge = (t >= {1'b0, r_cnt[g-1]});
        assign d  = t - {1'b0, r_cnt[g-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= r_vld[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= ge ? d[CNT_W-1:0] : t[CNT_W-1:0];
            r_low[g]  <= {r_low[g-1][MEAN_W-2:0], 1'b0};
            r_quo[g]  <= {r_quo[g-1][MEAN_W-2:0], ge};
            r_cnt[g]  <= r_cnt[g-1];
            r_neg[g]  <= r_neg[g-1];
            r_zero[g] <= r_zero[g-1];
            r_ovf[g]  <= r_ovf[g-1];
        end
    end

    // sign and clamp on the way out
    assign q = r_quo[S];

    always_comb begin
        if (r_zero[S]) begin
            o_mean = '0;
        end else if (!r_neg[S]) begin
            o_mean = (r_ovf[S] || q > MEAN_MAX) ? MEAN_MAX : q;
        end else begin
            o_mean = (r_ovf[S] || q > 24'h800000) ? MEAN_MIN : MEAN_W'(-q);
        end
    end

    assign o_vld  = r_vld[S];
    assign o_busy = |r_vld;

endmodule

FILE: rtl/nicv_sdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle, 64-bit divisor.
// Depends on nicv_pkg.
module nicv_sdiv (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [nicv_pkg::DEV_W-1:0]      i_rem0,
    input  logic [nicv_pkg::DEV_W-1:0]      i_numer,
    input  logic [nicv_pkg::DEV_W-1:0]      i_divisor,
    input  logic [nicv_pkg::STEP_W-1:0]     i_steps,
    output logic                            o_busy,
    output logic                            o_done,
    output logic [nicv_pkg::DEV_W-1:0]      o_quo
);
    import nicv_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic [DEV_W-1:0]    r_rem;
    logic [DEV_W-1:0]    r_num;
    logic [DEV_W-1:0]    r_div;
    logic [DEV_W-1:0]    r_quo;

    logic [DEV_W:0]      t;
    logic [DEV_W:0]      d;
    logic                ge;

    assign t  = {r_rem, r_num[DEV_W-1]};
    assign ge = (t >= {1'b0, r_div});
    assign d  = t - {1'b0, r_div};

    // step counter and handshake flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder / quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem0;
            r_num <= i_numer;
            r_div <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? d[DEV_W-1:0] : t[DEV_W-1:0];
            r_num <= {r_num[DEV_W-2:0], 1'b0};
            r_quo <= {r_quo[DEV_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: rtl/nicv_sqrt.sv
// Digit-by-digit integer square root of a 48-bit value, one result bit per cycle.
// Depends on nicv_pkg.
module nicv_sqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [2*nicv_pkg::RATIO_W-1:0]    i_x,
    output logic                              o_busy,
    output logic                              o_done,
    output logic [nicv_pkg::RATIO_W-1:0]      o_root
);
    import nicv_pkg::*;

    localparam int X_W   = 2 * RATIO_W;
    localparam int REM_W = RATIO_W + 3;
    localparam int CNT_W5 = $clog2(RATIO_W + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W5-1:0]   r_cnt;
    logic [X_W-1:0]      r_x;
    logic [REM_W-1:0]    r_rem;
    logic [RATIO_W-1:0]  r_root;

    logic [REM_W-1:0]    rem_sh;
    logic [REM_W-1:0]    trial;
    logic                ge;

    assign rem_sh = {r_rem[REM_W-3:0], r_x[X_W-1:X_W-2]};
    assign trial  = REM_W'({r_root, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W5'(RATIO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W5'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // two radicand bits in, one root bit out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_x;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[X_W-3:0], 2'b00};
            r_rem  <= ge ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[RATIO_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: rtl/nicv_dpath.sv
// Datapath: statistics memories, mean pipeline, class-mean accumulators, ratio units.
// Depends on nicv_pkg, nicv_mdiv, nicv_sdiv, nicv_sqrt and the assertion macros.
`include "nicv_leakage_locator_macros.svh"

module nicv_dpath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  nicv_pkg::t_cmd                         i_cmd,
    output nicv_pkg::t_sts                         o_sts,
    input  logic                                   i_cfg_wr_en,
    input  logic        [nicv_pkg::LIMIT_W-1:0]    i_cfg_wr_data,
    input  logic        [nicv_pkg::CLASS_W-1:0]    i_class_value,
    input  logic signed [nicv_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                                   i_stall,
    output logic                                   o_valid,
    output logic        [nicv_pkg::POINT_W-1:0]    o_point_index,
    output logic        [nicv_pkg::RATIO_W-1:0]    o_leakage_ratio,
    output logic                                   o_undefined
);
    import nicv_pkg::*;

    // memories
    logic [CNT_W-1:0]  mem_cc [0:CLASSES-1];
    logic [SUM_W-1:0]  mem_ps [0:POINTS-1];
    logic [DEV_W-1:0]  mem_ds [0:POINTS-1];
    logic [SUM_W-1:0]  mem_cs [0:CLASSES*POINTS-1];
    logic [CLASSES-1:0] r_cc_v;
    logic [POINTS-1:0]  r_ps_v;
    logic [POINTS-1:0]  r_ds_v;

    // registers
    logic [LIMIT_W-1:0]        r_points;
    logic [POINT_W-1:0]        r_pc;
    logic [ADDR_W-1:0]         r_clr;
    logic [CLASS_W-1:0]        r_cls;
    logic signed [SAMPLE_W-1:0] r_smp;
    logic [POINT_W-1:0]        r_p;
    logic [CNT_W-1:0]          r_trace;
    logic [CNT_W-1:0]          r_cc_rd;
    logic                      r_cc_rdv;
    logic [SUM_W-1:0]          r_cs_rd;
    logic [SUM_W-1:0]          r_ps_rd;
    logic                      r_ps_rdv;
    logic [DEV_W-1:0]          r_ds_rd;
    logic                      r_ds_rdv;
    logic [SUM_W-1:0]          r_psum;
    logic [DEV_W-1:0]          r_devold;
    logic signed [MEAN_W:0]    r_diff;
    logic [2*MEAN_W+1:0]       r_sq;
    logic [DEV_W-1:0]          r_dev;
    logic [CLASS_W-1:0]        r_j;
    logic                      r_rd_vld;
    logic signed [MEAN_W-1:0]  r_m;
    logic                      r_m_vld;
    logic [2*MEAN_W-1:0]       r_msq;
    logic                      r_msq_vld;
    logic signed [S1_W-1:0]    r_s1;
    logic [S2_W-1:0]           r_s2;
    logic [K_W-1:0]            r_k;
    logic [DEV_W-1:0]          r_s1sq;
    logic [DEV_W-1:0]          r_num;
    logic [2*K_W-2:0]          r_kk;
    logic [DEV_W-1:0]          r_var;
    logic [RATIO_W-1:0]        r_ratio;
    logic                      r_undef;
    logic                      r_out_vld;
    logic [POINT_W-1:0]        r_out_p;
    logic [RATIO_W-1:0]        r_out_ratio;
    logic                      r_out_undef;

    // combinational
    logic [LIMIT_W-1:0]        lim;
    logic [POINT_W-1:0]        cur_p;
    logic [LIMIT_W-1:0]        nxt_p;
    logic [CNT_W-1:0]          cc_eff;
    logic [SUM_W-1:0]          smp_ext;
    logic [SUM_W-1:0]          new_cs;
    logic [SUM_W-1:0]          new_ps;
    logic [CLASS_W-1:0]        cc_ra;
    logic [ADDR_W-1:0]         cs_ra;
    logic [ADDR_W-1:0]         cs_wa;
    logic signed [MEAN_W:0]    smp_q8;
    logic [DEV_W:0]            nd;
    logic [S1_W-1:0]           a1;
    logic [DEV_W-1:0]          vnum;
    logic                      k_zero;

    logic                      md_vld;
    logic signed [SUM_W-1:0]   md_sum;
    logic [CNT_W-1:0]          md_cnt;
    logic                      md_out_vld;
    logic signed [MEAN_W-1:0]  md_mean;
    logic                      md_busy;

    logic                      sd_start;
    logic [DEV_W-1:0]          sd_rem0;
    logic [DEV_W-1:0]          sd_numer;
    logic [DEV_W-1:0]          sd_div;
    logic [STEP_W-1:0]         sd_steps;
    logic                      sd_busy;
    logic                      sd_done;
    logic [DEV_W-1:0]          sd_quo;

    logic                      sq_busy;
    logic                      sq_done;
    logic [RATIO_W-1:0]        sq_root;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= LIMIT_W'(POINTS);
        end else if (i_cfg_wr_en) begin
            r_points <= i_cfg_wr_data;
        end
    end

    // trace length and point counter
    always_comb begin
        if (r_points == '0) begin
            lim = LIMIT_W'(1);
        end else if (r_points > LIMIT_W'(POINTS)) begin
            lim = LIMIT_W'(POINTS);
        end else begin
            lim = r_points;
        end
        cur_p = ({1'b0, r_pc} >= lim) ? '0 : r_pc;
        nxt_p = {1'b0, cur_p} + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= '0;
            r_trace <= '0;
            r_clr   <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_pc <= (nxt_p >= lim) ? '0 : nxt_p[POINT_W-1:0];
            end
            if (i_cmd.upd && r_p == '0) begin
                r_trace <= r_trace + 1'b1;
            end
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cls <= i_class_value;
            r_smp <= i_sample;
            r_p   <= cur_p;
        end
    end

    // memory addressing and update values
    assign cc_ra   = i_cmd.walk_rd ? r_j : r_cls;
    assign cs_ra   = i_cmd.walk_rd ? {r_j, r_p} : {r_cls, r_p};
    assign cs_wa   = i_cmd.clr_wr ? r_clr : {r_cls, r_p};
    assign cc_eff  = r_cc_rdv ? r_cc_rd : '0;
    assign smp_ext = SUM_W'(r_smp);
    assign new_cs  = r_cs_rd + smp_ext;
    assign new_ps  = (r_ps_rdv ? r_ps_rd : '0) + smp_ext;

    // registered memory reads
    always_ff @(posedge i_clk) begin
        r_cc_rd  <= mem_cc[cc_ra];
        r_cc_rdv <= r_cc_v[cc_ra];
        r_cs_rd  <= mem_cs[cs_ra];
        r_ps_rd  <= mem_ps[r_p];
        r_ps_rdv <= r_ps_v[r_p];
        r_ds_rd  <= mem_ds[r_p];
        r_ds_rdv <= r_ds_v[r_p];
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            mem_cs[cs_wa] <= '0;
        end else if (i_cmd.upd) begin
            mem_cs[cs_wa] <= new_cs;
        end
        if (i_cmd.upd) begin
            mem_ps[r_p] <= new_ps;
            if (r_p == '0) begin
                mem_cc[r_cls] <= cc_eff + 1'b1;
            end
        end
        if (i_cmd.dev_wr) begin
            mem_ds[r_p] <= nd[DEV_W] ? '1 : nd[DEV_W-1:0];
        end
    end

    // entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc_v <= '0;
            r_ps_v <= '0;
            r_ds_v <= '0;
        end else begin
            if (i_cmd.upd) begin
                r_ps_v[r_p] <= 1'b1;
                if (r_p == '0) begin
                    r_cc_v[r_cls] <= 1'b1;
                end
            end
            if (i_cmd.dev_wr) begin
                r_ds_v[r_p] <= 1'b1;
            end
        end
    end

    // point mean, deviation term and running deviation sum
    assign smp_q8 = {r_smp[SAMPLE_W-1], r_smp, 8'h00};
    assign nd     = {1'b0, r_devold} + (DEV_W+1)'(r_sq);

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_psum   <= new_ps;
            r_devold <= r_ds_rdv ? r_ds_rd : '0;
        end
        if (i_cmd.mean_cap && md_out_vld) begin
            r_diff <= smp_q8 - (MEAN_W+1)'(md_mean);
        end
        if (i_cmd.sq) begin
            r_sq <= r_diff * r_diff;
        end
        if (i_cmd.dev_wr) begin
            r_dev <= nd[DEV_W] ? '1 : nd[DEV_W-1:0];
        end
    end

    // mean divider: point mean first, then one class per cycle during the walk
    assign md_vld = i_cmd.mean_go || (r_rd_vld && cc_eff != '0);
    assign md_sum = i_cmd.mean_go ? r_psum : r_cs_rd;
    assign md_cnt = i_cmd.mean_go ? r_trace : cc_eff;

    nicv_mdiv u_mdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (md_vld),
        .i_sum   (md_sum),
        .i_cnt   (md_cnt),
        .o_vld   (md_out_vld),
        .o_mean  (md_mean),
        .o_busy  (md_busy)
    );

    // class walk and moment accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_m_vld   <= 1'b0;
            r_msq_vld <= 1'b0;
            r_k       <= '0;
            r_j       <= '0;
        end else begin
            r_rd_vld  <= i_cmd.walk_rd;
            r_m_vld   <= md_out_vld && !i_cmd.mean_cap;
            r_msq_vld <= r_m_vld;
            if (i_cmd.dev_wr) begin
                r_k <= '0;
                r_j <= '0;
            end else begin
                if (i_cmd.walk_rd) begin
                    r_j <= r_j + 1'b1;
                end
                if (r_m_vld) begin
                    r_k <= r_k + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m <= md_mean;
        if (r_m_vld) begin
            r_msq <= r_m * r_m;
        end
        if (i_cmd.dev_wr) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else begin
            if (r_m_vld) begin
                r_s1 <= r_s1 + S1_W'(r_m);
            end
            if (r_msq_vld) begin
                r_s2 <= r_s2 + S2_W'(r_msq);
            end
        end
    end

    // variance numerator and denominator
    assign a1     = r_s1[S1_W-1] ? S1_W'(-r_s1) : r_s1;
    assign k_zero = (r_k == '0);
    assign vnum   = (r_num >= r_s1sq) ? r_num - r_s1sq : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.num) begin
            r_s1sq <= a1 * a1;
            r_num  <= r_k * r_s2;
            r_kk   <= r_k * r_k;
        end
        if (i_cmd.var_cap) begin
            r_var <= sd_quo;
        end
    end

    // shared serial divider: variance, then the deviation ratio
    // ratio: var * 2^32 / dev, starting from var >> 16 which is below dev
    always_comb begin
        sd_start = i_cmd.vdiv_go || i_cmd.qdiv_go;
        if (i_cmd.qdiv_go) begin
            sd_rem0  = DEV_W'(r_var[DEV_W-1:16]);
            sd_numer = {r_var[15:0], 48'h0};
            sd_div   = r_dev;
            sd_steps = STEP_W'(48);
        end else begin
            sd_rem0  = '0;
            sd_numer = k_zero ? '0 : vnum;
            sd_div   = k_zero ? DEV_W'(1) : DEV_W'(r_kk);
            sd_steps = STEP_W'(DEV_W);
        end
    end

    nicv_sdiv u_sdiv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sd_start),
        .i_rem0    (sd_rem0),
        .i_numer   (sd_numer),
        .i_divisor (sd_div),
        .i_steps   (sd_steps),
        .o_busy    (sd_busy),
        .o_done    (sd_done),
        .o_quo     (sd_quo)
    );

    nicv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_go),
        .i_x     (sd_quo[2*RATIO_W-1:0]),
        .o_busy  (sq_busy),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // result selection
    always_ff @(posedge i_clk) begin
        if (i_cmd.chk) begin
            r_undef <= o_sts.dev_zero;
            r_ratio <= (o_sts.var_sat && !o_sts.dev_zero) ? RATIO_MAX : '0;
        end else if (i_cmd.root_cap) begin
            r_ratio <= sq_root;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_p     <= r_p;
            r_out_ratio <= r_ratio;
            r_out_undef <= r_undef;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_point_index   = r_out_p;
    assign o_leakage_ratio = r_out_ratio;
    assign o_undefined     = r_out_undef;

    // status to the controller
    always_comb begin
        o_sts.clr_last   = (r_clr == '1);
        o_sts.walk_last  = (r_j == CLASS_W'(CLASSES - 1));
        o_sts.pipe_empty = !r_rd_vld && !md_busy && !r_m_vld && !r_msq_vld;
        o_sts.mean_vld   = md_out_vld;
        o_sts.sdiv_done  = sd_done;
        o_sts.sqrt_done  = sq_done;
        o_sts.dev_zero   = (r_dev == '0);
        o_sts.var_sat    = ((r_var >> 16) >= r_dev);
        o_sts.out_free   = !r_out_vld || !i_stall;
    end

    `NICV_ASSERT_IMP(a_sdiv_free, i_cmd.vdiv_go || i_cmd.qdiv_go, !sd_busy && !sq_busy)
    `NICV_ASSERT_IMP(a_mean_alone, i_cmd.mean_go, !md_busy && !r_rd_vld && !r_m_vld)
    `NICV_ASSERT_ALWAYS(a_k_range, r_k <= K_W'(CLASSES))

endmodule

FILE: rtl/nicv_ctrl.sv
// Controller state machine sequencing one sample through the datapath.
// Depends on nicv_pkg and the assertion macros.
`include "nicv_leakage_locator_macros.svh"

module nicv_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  nicv_pkg::t_sts  i_sts,
    output nicv_pkg::t_cmd  o_cmd,
    output logic            o_stall
);
    import nicv_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (i_sts.clr_last)   n_state = ST_IDLE;
            ST_IDLE:  if (i_valid)          n_state = ST_READ;
            ST_READ:                        n_state = ST_UPD;
            ST_UPD:                         n_state = ST_MEAN;
            ST_MEAN:                        n_state = ST_MEANW;
            ST_MEANW: if (i_sts.mean_vld)   n_state = ST_SQ;
            ST_SQ:                          n_state = ST_DEVW;
            ST_DEVW:                        n_state = ST_WALK;
            ST_WALK:  if (i_sts.walk_last)  n_state = ST_DRAIN;
            ST_DRAIN: if (i_sts.pipe_empty) n_state = ST_NUM;
            ST_NUM:                         n_state = ST_VGO;
            ST_VGO:                         n_state = ST_VDIV;
            ST_VDIV:  if (i_sts.sdiv_done)  n_state = ST_CHK;
            ST_CHK: begin
                if (i_sts.dev_zero || i_sts.var_sat) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_QDIV;
                end
            end
            ST_QDIV:  if (i_sts.sdiv_done)  n_state = ST_SQRT;
            ST_SQRT:  if (i_sts.sqrt_done)  n_state = ST_DONE;
            ST_DONE:  if (i_sts.out_free)   n_state = ST_IDLE;
            default:                        n_state = ST_CLEAR;
        endcase
    end

    // commands
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_CLEAR: o_cmd.clr_wr = 1'b1;
            ST_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            ST_READ:  ;
            ST_UPD:   o_cmd.upd = 1'b1;
            ST_MEAN:  o_cmd.mean_go = 1'b1;
            ST_MEANW: o_cmd.mean_cap = 1'b1;
            ST_SQ:    o_cmd.sq = 1'b1;
            ST_DEVW:  o_cmd.dev_wr = 1'b1;
            ST_WALK:  o_cmd.walk_rd = 1'b1;
            ST_DRAIN: ;
            ST_NUM:   o_cmd.num = 1'b1;
            ST_VGO:   o_cmd.vdiv_go = 1'b1;
            ST_VDIV:  o_cmd.var_cap = i_sts.sdiv_done;
            ST_CHK: begin
                o_cmd.chk     = 1'b1;
                o_cmd.qdiv_go = !(i_sts.dev_zero || i_sts.var_sat);
            end
            ST_QDIV:  o_cmd.sqrt_go = i_sts.sdiv_done;
            ST_SQRT:  o_cmd.root_cap = i_sts.sqrt_done;
            ST_DONE:  o_cmd.out_load = i_sts.out_free;
            default:  ;
        endcase
    end

    `NICV_ASSERT_NXT(a_done_leaves, r_state == ST_DONE && i_sts.out_free, r_state == ST_IDLE)

endmodule

FILE: rtl/nicv_leakage_locator.sv
// Leakage locator top level: one request at a time, each run to its result before the next is
// accepted; a saturated or undefined ratio skips the ratio division and the square root.
// Steps: class walk, mean pipeline, 64- and 48-step serial divider, 24-step square root.
// A result waits in an output register while the next request runs.
// Reset: synchronous, active low; afterwards a clearing pass over the whole
// class-sum memory holds o_stall high. Configuration writes are taken at any time.
module nicv_leakage_locator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic        [nicv_pkg::LIMIT_W-1:0]    i_cfg_wr_data,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic        [nicv_pkg::CLASS_W-1:0]    i_class_value,
    input  logic signed [nicv_pkg::SAMPLE_W-1:0]   i_sample,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic        [nicv_pkg::POINT_W-1:0]    o_point_index,
    output logic        [nicv_pkg::RATIO_W-1:0]    o_leakage_ratio,
    output logic                                   o_undefined
);
    import nicv_pkg::*;

    t_cmd cmd;
    t_sts sts;

    nicv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    nicv_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_class_value   (i_class_value),
        .i_sample        (i_sample),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_point_index   (o_point_index),
        .o_leakage_ratio (o_leakage_ratio),
        .o_undefined     (o_undefined)
    );

endmodule

FILE: tb/nicv_leakage_locator_tb.sv
// Self-checking testbench for nicv_leakage_locator: directed table, then random traces.
// Carries its own fixed-point leakage predictor; depends on nicv_pkg and the RTL only.
`timescale 1ns / 1ps

module nicv_leakage_locator_tb;
    import nicv_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int NUM_PHASES     = 10;

    typedef struct {
        logic [POINT_W-1:0] point;
        logic [RATIO_W-1:0] ratio;
        logic               undef;
    } t_leak_result;

    typedef struct {
        logic [CLASS_W-1:0]         cls;
        logic signed [SAMPLE_W-1:0] smp;
        bit                         typed;
        logic [RATIO_W-1:0]         ratio;
        logic                       undef;
    } t_dir_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0]         i_cfg_wr_data = '0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic [CLASS_W-1:0]         i_class_value = '0;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [POINT_W-1:0]         o_point_index;
    logic [RATIO_W-1:0]         o_leakage_ratio;
    logic                       o_undefined;

    nicv_leakage_locator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_class_value   (i_class_value),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_point_index   (o_point_index),
        .o_leakage_ratio (o_leakage_ratio),
        .o_undefined     (o_undefined)
    );

    // Predictor state
    logic [LIMIT_W-1:0] trace_len_reg;
    int unsigned        pt_ctr;
    logic [CNT_W-1:0]   n_traces;
    logic [CNT_W-1:0]   cls_traces [CLASSES];
    logic [SUM_W-1:0]   cls_acc    [CLASSES*POINTS];
    logic [SUM_W-1:0]   pt_acc     [POINTS];
    logic [DEV_W-1:0]   sq_dev_acc [POINTS];

    t_leak_result expected_results [$];
    int           error_count = 0;
    int           idle_cycles = 0;
    bit           burst_mode  = 1'b0;
    int           stall_left  = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    // Q.8 mean, truncated toward zero and clamped to 24 bits
    function automatic longint mean_q8(input logic [SUM_W-1:0] sum, input logic [CNT_W-1:0] cnt);
        longint      s;
        logic [63:0] mag;
        s = longint'($signed(sum));
        if (cnt == 0) return 0;
        mag = (s < 0) ? 64'(-s) : 64'(s);
        mag = (mag << 8) / {32'd0, cnt};
        if (s < 0) return (mag > 64'h800000) ? -longint'(64'h800000) : -longint'(mag);
        return (mag > 64'h7FFFFF) ? longint'(64'h7FFFFF) : longint'(mag);
    endfunction

    // floor(b * 2^32 / d) for b < d
    function automatic logic [63:0] frac_div32(input logic [63:0] b, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = 0;
        r = {1'b0, b};
        for (int i = 0; i < 32; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Update the accumulators with one request and return the leakage result it causes
    function automatic t_leak_result predict_leakage(input logic [CLASS_W-1:0] cls,
                                                     input logic signed [SAMPLE_W-1:0] smp);
        t_leak_result res;
        int unsigned  lim, p, k, idx;
        longint       mean, diff, m, s1;
        logic [63:0]  sq, nd, s2, a1, num, var_q16, dev, q;
        lim = trace_len_reg;
        if (lim == 0) lim = 1;
        if (lim > POINTS) lim = POINTS;
        if (pt_ctr >= lim) pt_ctr = 0;
        p = pt_ctr;
        // trace start
        if (p == 0) begin
            n_traces++;
            cls_traces[cls]++;
        end
        idx = cls * POINTS + p;
        cls_acc[idx] = cls_acc[idx] + SUM_W'(longint'(smp));
        pt_acc[p]    = pt_acc[p] + SUM_W'(longint'(smp));
        mean = mean_q8(pt_acc[p], n_traces);
        diff = longint'(smp) * 256 - mean;
        sq   = 64'(diff * diff);
        nd   = sq_dev_acc[p] + sq;
        sq_dev_acc[p] = (nd < sq) ? '1 : nd;
        // walk class means of non-empty classes
        s1 = 0; s2 = 0; k = 0; var_q16 = 0;
        for (int j = 0; j < CLASSES; j++) begin
            if (cls_traces[j] != 0) begin
                m  = mean_q8(cls_acc[j*POINTS + p], cls_traces[j]);
                s1 += m;
                s2 += 64'(m * m);
                k++;
            end
        end
        if (k != 0) begin
            a1  = (s1 < 0) ? 64'(-s1) : 64'(s1);
            num = 64'(k) * s2;
            num = (num >= a1 * a1) ? num - a1 * a1 : 0;
            var_q16 = num / (64'(k) * 64'(k));
        end
        dev = sq_dev_acc[p];
        res.point = p[POINT_W-1:0];
        res.undef = 1'b0;
        res.ratio = '0;
        if (dev == 0) begin
            res.undef = 1'b1;
        end else if ((var_q16 >> 16) >= dev) begin
            res.ratio = RATIO_MAX;
        end else begin
            q = ((var_q16 / dev) << 32) + frac_div32(var_q16 % dev, dev);
            q = int_sqrt(q);
            res.ratio = (q > 64'hFFFFFF) ? RATIO_MAX : q[RATIO_W-1:0];
        end
        pt_ctr = (p + 1 >= lim) ? 0 : p + 1;
        return res;
    endfunction

    // Drive one request; called just after a rising edge
    task automatic send_sample(input logic [CLASS_W-1:0] cls, input logic signed [SAMPLE_W-1:0] smp,
                               input bit typed, input t_leak_result want);
        int           gap;
        t_leak_result pred;
        gap = burst_mode ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_class_value <= cls;
        i_sample      <= smp;
        do @(posedge i_clk); while (o_stall);
        pred = predict_leakage(cls, smp);
        expected_results.insert(expected_results.size(), typed ? want : pred);
    endtask

    task automatic write_trace_len(input logic [LIMIT_W-1:0] len);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        trace_len_reg = len;
    endtask

    // Result side: check against the oldest expectation, then draw the next stall
    always @(posedge i_clk) begin
        t_leak_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, point", o_point_index, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_point_index !== want.point)
                    report_mismatch("point_index", o_point_index, want.point);
                if (o_leakage_ratio !== want.ratio)
                    report_mismatch("leakage_ratio", o_leakage_ratio, want.ratio);
                if (o_undefined !== want.undef)
                    report_mismatch("undefined", o_undefined, want.undef);
            end
            stall_left = burst_mode ? 0 : $urandom_range(0, 7);
            i_stall <= (stall_left != 0);
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= (stall_left != 0);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_dir_row          dir_rows [12];
        t_leak_result      want;
        logic [LIMIT_W-1:0] phase_len   [NUM_PHASES];
        int                phase_items [NUM_PHASES];
        logic [CLASS_W-1:0] cls;
        logic signed [SAMPLE_W-1:0] smp;
        int                sel;

        // directed rows; typed expectations only where obvious
        dir_rows = '{
            '{8'd0,   16'sd0,      1'b1, 24'h0,     1'b1},  // first sample after reset
            '{8'd255, 16'sh7FFF,   1'b1, 24'h0,     1'b1},  // single trace, no deviation
            '{8'd7,   -16'sh8000,  1'b1, 24'h0,     1'b1},
            '{8'd255, -16'sh8000,  1'b1, 24'h10000, 1'b0},  // second trace, two classes
            '{8'd128, 16'sh7FFF,   1'b0, 24'h0,     1'b0},  // class mismatch within trace
            '{8'd1,   16'sh5555,   1'b0, 24'h0,     1'b0},
            '{8'd0,   16'shAAAA,   1'b0, 24'h0,     1'b0},
            '{8'd127, 16'sh7FFF,   1'b0, 24'h0,     1'b0},
            '{8'd127, 16'sh7FFF,   1'b0, 24'h0,     1'b0},
            '{8'd85,  -16'sd1,     1'b0, 24'h0,     1'b0},
            '{8'd170, 16'sd1,      1'b0, 24'h0,     1'b0},
            '{8'd255, 16'sh7FFF,   1'b0, 24'h0,     1'b0}
        };
        phase_len   = '{9'd3, 9'd256, 9'd1, 9'd0, 9'd17, 9'd3, 9'd300, 9'd511, 9'd5, 9'd256};
        phase_items = '{0, 400, 50, 50, 100, 100, 300, 200, 150, 150};

        trace_len_reg = 9'd256;
        pt_ctr        = 0;
        n_traces      = 0;
        foreach (cls_traces[j]) cls_traces[j] = 0;
        foreach (cls_acc[j]) cls_acc[j] = 0;
        foreach (pt_acc[j]) pt_acc[j] = 0;
        foreach (sq_dev_acc[j]) sq_dev_acc[j] = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_trace_len(phase_len[ph]);
            if (ph == 0) begin
                foreach (dir_rows[r]) begin
                    want.point = pt_ctr[POINT_W-1:0];
                    want.ratio = dir_rows[r].ratio;
                    want.undef = dir_rows[r].undef;
                    send_sample(dir_rows[r].cls, dir_rows[r].smp, dir_rows[r].typed, want);
                end
            end
            for (int n = 0; n < phase_items[ph]; n++) begin
                if (n % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
                // mostly a handful of classes, so class means separate
                cls = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
                sel = $urandom_range(0, 7);
                if (sel == 0)
                    smp = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
                else if (sel < 4)
                    smp = 16'($urandom);
                else
                    smp = 16'(int'(cls[1:0]) * 3000 - 4000 + $urandom_range(0, 800));
                send_sample(cls, smp, 1'b0, want);
            end
        end
        i_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/nicv_pkg.sv
rtl/nicv_mdiv.sv
rtl/nicv_sdiv.sv
rtl/nicv_sqrt.sv
rtl/nicv_dpath.sv
rtl/nicv_ctrl.sv
rtl/nicv_leakage_locator.sv
tb/nicv_leakage_locator_tb.sv
